### hw/rtl/fbm_pkg.sv
// Shared constants, types and the normalization table of the fbm value noise block.
// No dependencies; imported by fbm_cell, fbm_norm, fbm_value_noise and the testbench.
`default_nettype none

package fbm_pkg;

   localparam logic [31:0] HASH_MX   = 32'd374761393;
   localparam logic [31:0] HASH_MY   = 32'd668265263;
   localparam logic [31:0] HASH_MS   = 32'd1274126177;
   localparam logic [31:0] HASH_MF   = 32'd1103515245;
   localparam logic [31:0] SEED_STEP = 32'd31;

   // 3.0 in Q.16 for the smoothstep term
   localparam logic [17:0] SMOOTH_THREE = 18'h30000;

   localparam int OCT_W = 5;

   localparam logic [1:0] CSR_NOISE_SEED   = 2'd0;
   localparam logic [1:0] CSR_BASE_SCALE   = 2'd1;
   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd2;

   localparam logic [15:0] SCALE_RESET = 16'd5243;
   localparam logic [3:0]  OCT_RESET   = 4'd4;

   typedef struct packed {
      logic [31:0]      seed;
      logic [OCT_W-1:0] octaves;
   } fbm_cfg_type;

   // ceil(2^32 / (2^k - 1)); one octave is passed through and has no entry
   function automatic logic [31:0] fbm_recip(input logic [OCT_W-1:0] k);
      logic [31:0] r;
      case (k)
         5'd2:    r = 32'd1431655766;
         5'd3:    r = 32'd613566757;
         5'd4:    r = 32'd286331154;
         5'd5:    r = 32'd138547333;
         5'd6:    r = 32'd68174085;
         5'd7:    r = 32'd33818641;
         5'd8:    r = 32'd16843010;
         5'd9:    r = 32'd8405025;
         5'd10:   r = 32'd4198405;
         5'd11:   r = 32'd2098177;
         5'd12:   r = 32'd1048833;
         5'd13:   r = 32'd524353;
         5'd14:   r = 32'd262161;
         5'd15:   r = 32'd131077;
         5'd16:   r = 32'd65538;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fbm_cell.sv
// One octave cell of the fbm chain: corner hash, smoothstep, bilinear blend, accumulate.
// Eight stages; hands coordinates and accumulator to the next cell. Uses fbm_pkg.
`default_nettype none

module fbm_cell
   import fbm_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int PW    = 28,
   parameter int ACC_W = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire fbm_cfg_type       cfg,
   input  wire logic              valid_i,
   input  wire logic [PW-1:0]     prod_x_i,
   input  wire logic [PW-1:0]     prod_y_i,
   input  wire logic [ACC_W-1:0]  acc_i,
   output logic                   valid_o,
   output logic [PW-1:0]          prod_x_o,
   output logic [PW-1:0]          prod_y_o,
   output logic [ACC_W-1:0]       acc_o
);

   localparam int NST = 8;

   logic [31:0] seed_ff;

   logic          vld_ff [1:NST];
   logic [PW-1:0] px_ff  [1:NST];
   logic [PW-1:0] py_ff  [1:NST];
   logic [ACC_W-1:0] acc_ff [1:NST-1];

   // stage 1
   logic [63:0] pos_x, pos_y;
   logic [31:0] cx, cy;
   logic [15:0] fx, fy;
   logic [31:0] sqx, sqy;
   logic [31:0] am_ff, bm_ff, cm_ff;
   logic [31:0] am_in, bm_in, cm_in;
   logic [15:0] d2x_ff, d2y_ff;
   logic [17:0] tx_ff, ty_ff, tx_in, ty_in;

   // stage 2
   logic [31:0] hsum, h00, h10, h01, h11;
   logic [31:0] hx_ff [0:3];
   logic [31:0] hx_in [0:3];
   logic [33:0] smx, smy;
   logic [15:0] sx2_ff, sy2_ff;

   // stage 3
   logic [31:0] hm_ff [0:3];
   logic [15:0] sx3_ff, sy3_ff;

   // stage 4
   logic [15:0] n00, n10, n01, n11;
   logic [15:0] n00_4_ff, n01_4_ff;
   logic signed [16:0] dtop_ff, dbot_ff;
   logic [15:0] sx4_ff, sy4_ff;

   // stage 5
   logic [15:0] n00_5_ff, n01_5_ff;
   logic signed [33:0] ptop_ff, pbot_ff;
   logic [15:0] sy5_ff;

   // stage 6
   logic signed [33:0] top_sum, bot_sum;
   logic [15:0] top_in, bot_in;
   logic [15:0] top6_ff, sy6_ff;
   logic signed [16:0] dv_ff;

   // stage 7
   logic [15:0] top7_ff;
   logic signed [33:0] pv_ff;

   // stage 8
   logic signed [33:0] v_sum;
   logic [15:0] v_val;
   logic [ACC_W-1:0] acc_o_in;
   logic [ACC_W-1:0] acc_o_ff;

   always_comb begin
      pos_x = 64'(prod_x_i) << IDX;
      pos_y = 64'(prod_y_i) << IDX;
      cx    = pos_x[47:16];
      cy    = pos_y[47:16];
      fx    = pos_x[15:0];
      fy    = pos_y[15:0];
      am_in = cx * HASH_MX;
      bm_in = cy * HASH_MY;
      cm_in = seed_ff * HASH_MS;
      sqx   = 32'(fx) * 32'(fx);
      sqy   = 32'(fy) * 32'(fy);
      tx_in = SMOOTH_THREE - {1'b0, fx, 1'b0};
      ty_in = SMOOTH_THREE - {1'b0, fy, 1'b0};
   end

   always_comb begin
      hsum = am_ff + bm_ff + cm_ff;
      h00  = hsum;
      h10  = hsum + HASH_MX;
      h01  = hsum + HASH_MY;
      h11  = hsum + (HASH_MX + HASH_MY);
      hx_in[0] = h00 ^ (h00 >> 13);
      hx_in[1] = h10 ^ (h10 >> 13);
      hx_in[2] = h01 ^ (h01 >> 13);
      hx_in[3] = h11 ^ (h11 >> 13);
      smx = 34'(d2x_ff) * 34'(tx_ff);
      smy = 34'(d2y_ff) * 34'(ty_ff);
   end

   always_comb begin
      n00 = hm_ff[0][15:0] ^ hm_ff[0][31:16];
      n10 = hm_ff[1][15:0] ^ hm_ff[1][31:16];
      n01 = hm_ff[2][15:0] ^ hm_ff[2][31:16];
      n11 = hm_ff[3][15:0] ^ hm_ff[3][31:16];
   end

   // a*(1-s) + b*s == a + (b-a)*s, exact under floor
   always_comb begin
      top_sum = $signed({18'd0, n00_5_ff}) + (ptop_ff >>> 16);
      bot_sum = $signed({18'd0, n01_5_ff}) + (pbot_ff >>> 16);
      top_in  = top_sum[15:0];
      bot_in  = bot_sum[15:0];
      v_sum   = $signed({18'd0, top7_ff}) + (pv_ff >>> 16);
      v_val   = v_sum[15:0];
      if (cfg.octaves > OCT_W'(IDX)) begin
         acc_o_in = ACC_W'({acc_ff[NST-1], 1'b0}) + ACC_W'(v_val);
      end else begin
         acc_o_in = acc_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= cfg.seed + 32'(SEED_STEP * IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[1] <= valid_i;
         for (int s = 2; s <= NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[1]  <= prod_x_i;
         py_ff[1]  <= prod_y_i;
         acc_ff[1] <= acc_i;
         for (int s = 2; s <= NST; s++) begin
            px_ff[s] <= px_ff[s-1];
            py_ff[s] <= py_ff[s-1];
         end
         for (int s = 2; s <= NST-1; s++) begin
            acc_ff[s] <= acc_ff[s-1];
         end

         am_ff  <= am_in;
         bm_ff  <= bm_in;
         cm_ff  <= cm_in;
         d2x_ff <= sqx[31:16];
         d2y_ff <= sqy[31:16];
         tx_ff  <= tx_in;
         ty_ff  <= ty_in;

         for (int j = 0; j < 4; j++) begin
            hx_ff[j] <= hx_in[j];
            hm_ff[j] <= hx_ff[j] * HASH_MF;
         end
         sx2_ff <= smx[31:16];
         sy2_ff <= smy[31:16];

         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;

         n00_4_ff <= n00;
         n01_4_ff <= n01;
         dtop_ff  <= $signed({1'b0, n10}) - $signed({1'b0, n00});
         dbot_ff  <= $signed({1'b0, n11}) - $signed({1'b0, n01});
         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;

         n00_5_ff <= n00_4_ff;
         n01_5_ff <= n01_4_ff;
         ptop_ff  <= dtop_ff * $signed({1'b0, sx4_ff});
         pbot_ff  <= dbot_ff * $signed({1'b0, sx4_ff});
         sy5_ff   <= sy4_ff;

         top6_ff <= top_in;
         dv_ff   <= $signed({1'b0, bot_in}) - $signed({1'b0, top_in});
         sy6_ff  <= sy5_ff;

         top7_ff <= top6_ff;
         pv_ff   <= dv_ff * $signed({1'b0, sy6_ff});

         acc_o_ff <= acc_o_in;
      end
   end

   assign valid_o  = vld_ff[NST];
   assign prod_x_o = px_ff[NST];
   assign prod_y_o = py_ff[NST];
   assign acc_o    = acc_o_ff;

endmodule

`default_nettype wire

### hw/rtl/fbm_norm.sv
// Normalization of the octave sum by the reciprocal of the total weight, with saturation.
// One registered multiply stage; result is combinational off it. Uses fbm_pkg.
`default_nettype none

module fbm_norm
   import fbm_pkg::*;
#(
   parameter int ACC_W = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic [OCT_W-1:0]  octaves,
   input  wire logic              valid_i,
   input  wire logic [ACC_W-1:0]  acc_i,
   output logic                   valid_o,
   output logic [15:0]            noise_o
);

   localparam int PROD_W = ACC_W + 32;

   logic              valid_ff;
   logic              single_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [PROD_W-1:0] mul_ff;
   logic [PROD_W-1:0] mul_in;
   logic [ACC_W-1:0]  hi;

   assign mul_in = PROD_W'(acc_i) * PROD_W'(fbm_recip(octaves));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff    <= mul_in;
         acc_ff    <= acc_i;
         single_ff <= (octaves == OCT_W'(1));
      end
   end

   always_comb begin
      hi = mul_ff[PROD_W-1:32];
      if (single_ff) begin
         noise_o = acc_ff[15:0];
      end else if (hi > ACC_W'(16'hFFFF)) begin
         noise_o = 16'hFFFF;
      end else begin
         noise_o = hi[15:0];
      end
   end

   assign valid_o = valid_ff;

endmodule

`default_nettype wire

### hw/rtl/fbm_value_noise.sv
// Top level of the fbm value noise block: config registers, entry multiply, octave chain,
// normalization and a two-entry output buffer. Uses fbm_pkg, fbm_cell and fbm_norm.
// A req beat goes through the entry register, octave cells, norm register and output register.
// Throughput: one beat per cycle while the skid is empty; octave cells are 8-stage pipelines.
// req_tready drops only while the output skid register holds a beat.
// Reset: synchronous; clears all valid bits, config goes to seed 0, scale 5243, 4 octaves.
`default_nettype none

module fbm_value_noise
   import fbm_pkg::*;
#(
   parameter int MAX_OCTAVES = 8,
   parameter int COORD_BITS  = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // coord_x [COORD_BITS-1:0], coord_y [2*COORD_BITS-1:COORD_BITS]
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // noise_value [15:0]
   output logic [15:0]                                 rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [1:0]                             csr_addr,
   input  wire logic [31:0]                            csr_wdata
);

   localparam int PW    = COORD_BITS + 16;
   localparam int ACC_W = 16 + MAX_OCTAVES;

   logic [31:0] seed_ff;
   logic [15:0] scale_ff;
   logic [3:0]  octc_ff;
   logic [OCT_W-1:0] oct_eff;
   fbm_cfg_type cfg;

   logic          en;
   logic          ent_valid_ff;
   logic [PW-1:0] ent_px_ff, ent_py_ff;

   logic             ch_valid [0:MAX_OCTAVES];
   logic [ACC_W-1:0] ch_acc   [0:MAX_OCTAVES];
   logic [PW-1:0]    ch_px    [0:MAX_OCTAVES-1];
   logic [PW-1:0]    ch_py    [0:MAX_OCTAVES-1];

   logic        norm_valid;
   logic [15:0] norm_noise;

   logic        out_valid_ff, skid_valid_ff;
   logic [15:0] out_ff, skid_ff;
   logic        take;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd0;
         scale_ff <= SCALE_RESET;
         octc_ff  <= OCT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NOISE_SEED:   seed_ff  <= csr_wdata;
            CSR_BASE_SCALE:   scale_ff <= csr_wdata[15:0];
            CSR_OCTAVE_COUNT: octc_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (octc_ff == 4'd0) begin
         oct_eff = OCT_W'(1);
      end else if (OCT_W'(octc_ff) > OCT_W'(MAX_OCTAVES)) begin
         oct_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_eff = OCT_W'(octc_ff);
      end
      cfg.seed    = seed_ff;
      cfg.octaves = oct_eff;
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_px_ff <= PW'(req_tdata[COORD_BITS-1:0]) * PW'(scale_ff);
         ent_py_ff <= PW'(req_tdata[2*COORD_BITS-1:COORD_BITS]) * PW'(scale_ff);
      end
   end

   assign ch_valid[0] = ent_valid_ff;
   assign ch_acc[0]   = '0;
   assign ch_px[0]    = ent_px_ff;
   assign ch_py[0]    = ent_py_ff;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      if (i < MAX_OCTAVES - 1) begin : g_mid
         fbm_cell #(
            .IDX   (i),
            .PW    (PW),
            .ACC_W (ACC_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .cfg      (cfg),
            .valid_i  (ch_valid[i]),
            .prod_x_i (ch_px[i]),
            .prod_y_i (ch_py[i]),
            .acc_i    (ch_acc[i]),
            .valid_o  (ch_valid[i+1]),
            .prod_x_o (ch_px[i+1]),
            .prod_y_o (ch_py[i+1]),
            .acc_o    (ch_acc[i+1])
         );
      end else begin : g_last
         fbm_cell #(
            .IDX   (i),
            .PW    (PW),
            .ACC_W (ACC_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .cfg      (cfg),
            .valid_i  (ch_valid[i]),
            .prod_x_i (ch_px[i]),
            .prod_y_i (ch_py[i]),
            .acc_i    (ch_acc[i]),
            .valid_o  (ch_valid[i+1]),
            .prod_x_o (),
            .prod_y_o (),
            .acc_o    (ch_acc[i+1])
         );
      end
   end

   fbm_norm #(
      .ACC_W (ACC_W)
   ) u_norm (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .octaves (oct_eff),
      .valid_i (ch_valid[MAX_OCTAVES]),
      .acc_i   (ch_acc[MAX_OCTAVES]),
      .valid_o (norm_valid),
      .noise_o (norm_noise)
   );

   // output register plus skid; the chain stalls only while the skid is full
   assign take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (en && norm_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (en && norm_valid) begin
         if (!out_valid_ff || take) begin
            out_ff <= norm_noise;
         end else begin
            skid_ff <= norm_noise;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat held without an output beat");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(ent_valid_ff) && $stable(ent_px_ff))
      else $error("chain moved while the skid was full");

   a_blocked_fills_skid: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && norm_valid && out_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("result beat lost at a blocked output");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> !skid_valid_ff && out_valid_ff)
      else $error("skid beat not moved to the output");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench of fbm_value_noise: directed and random coordinates under several register
// settings, checked beat by beat against a fixed-point fbm predictor in a scoreboard class.
// Depends on fbm_pkg (register indexes) and the fbm_value_noise RTL.
`timescale 1ns / 1ps

module tb;
   import fbm_pkg::*;

   localparam int          MAX_OCT     = 8;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          TAIL_CYCLES = 80;
   localparam logic [1:0]  CSR_SPARE   = 2'd3;
   localparam logic [31:0] MUL_X       = 32'd374761393;
   localparam logic [31:0] MUL_Y       = 32'd668265263;
   localparam logic [31:0] MUL_SEED    = 32'd1274126177;
   localparam logic [31:0] MUL_MIX     = 32'd1103515245;
   localparam logic [31:0] OCT_STEP    = 32'd31;

   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] value;
   } noise_sample_type;

   class noise_scoreboard;
      logic [31:0]      seed;
      logic [15:0]      scale;
      logic [3:0]       octaves;
      noise_sample_type samples_q[$];
      int               failures;

      function new();
         seed     = 32'd0;
         scale    = 16'd5243;
         octaves  = 4'd4;
         failures = 0;
      endfunction

      function void write_reg(logic [1:0] addr, logic [31:0] data);
         case (addr)
            CSR_NOISE_SEED:   seed = data;
            CSR_BASE_SCALE:   scale = data[15:0];
            CSR_OCTAVE_COUNT: octaves = data[3:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] corner_hash(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
         logic [31:0] h;
         h = cx * MUL_X + cy * MUL_Y + s * MUL_SEED;
         h = (h ^ (h >> 13)) * MUL_MIX;
         h = h ^ (h >> 16);
         return h[15:0];
      endfunction

      function logic [31:0] smooth(logic [15:0] d);
         logic [63:0] d2;
         logic [63:0] t;
         logic [63:0] p;
         d2 = ({48'd0, d} * {48'd0, d}) >> 16;
         t  = 64'd196608 - ({48'd0, d} << 1);
         p  = (d2 * t) >> 16;
         return p[31:0];
      endfunction

      function logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [31:0] s);
         logic [63:0] v;
         v = {48'd0, a} * (64'd65536 - {32'd0, s}) + {48'd0, b} * {32'd0, s};
         return v[31:16];
      endfunction

      function logic [15:0] octave_value(logic [11:0] x, logic [11:0] y, int i,
                                         logic [31:0] s);
         logic [63:0] px;
         logic [63:0] py;
         logic [31:0] cx;
         logic [31:0] cy;
         logic [31:0] sx;
         logic [31:0] sy;
         logic [15:0] top;
         logic [15:0] bot;
         px  = ({52'd0, x} * {48'd0, scale}) << i;
         py  = ({52'd0, y} * {48'd0, scale}) << i;
         cx  = px[47:16];
         cy  = py[47:16];
         sx  = smooth(px[15:0]);
         sy  = smooth(py[15:0]);
         top = lerp16(corner_hash(cx, cy, s), corner_hash(cx + 32'd1, cy, s), sx);
         bot = lerp16(corner_hash(cx, cy + 32'd1, s),
                      corner_hash(cx + 32'd1, cy + 32'd1, s), sx);
         return lerp16(top, bot, sy);
      endfunction

      function logic [15:0] fbm_sample(logic [11:0] x, logic [11:0] y);
         int          k;
         int          i;
         logic [31:0] oct_seed;
         logic [63:0] acc;
         logic [63:0] total;
         logic [63:0] recip;
         logic [63:0] scaled;
         k = octaves;
         if (k < 1) k = 1;
         if (k > MAX_OCT) k = MAX_OCT;
         acc = 64'd0;
         for (i = 0; i < k; i++) begin
            oct_seed = seed + OCT_STEP * i;
            acc += {48'd0, octave_value(x, y, i, oct_seed)} << (k - 1 - i);
         end
         total  = (64'd1 << k) - 64'd1;
         recip  = (64'h1_0000_0000 + total - 64'd1) / total;
         scaled = (acc * recip) >> 32;
         return (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
      endfunction

      function void note_request(logic [11:0] x, logic [11:0] y);
         noise_sample_type e;
         e.x     = x;
         e.y     = y;
         e.value = fbm_sample(x, y);
         samples_q.push_back(e);
      endfunction

      function void check_result(logic [15:0] got);
         noise_sample_type e;
         if (samples_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("rsp beat %0d with no request pending", got);
            return;
         end
         e = samples_q.pop_front();
         if (got !== e.value) begin
            failures++;
            if (failures <= 10)
               $display("noise mismatch at (%0d,%0d): expected %0d, got %0d",
                        e.x, e.y, e.value, got);
         end
      endfunction

      function int pending();
         return samples_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = 2'd0;
   logic [31:0] csr_wdata = 32'd0;
   logic        steady = 1'b0;
   int          cycles = 0;

   noise_scoreboard sb;

   fbm_value_noise dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 27);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) sb.note_request(req_tdata[11:0], req_tdata[23:12]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   task automatic send_point(input logic [11:0] x, input logic [11:0] y);
      while (!steady && $urandom_range(0, 99) < 27) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_noise(input logic [31:0] seed, input logic [31:0] scale,
                            input logic [31:0] octaves);
      drain();
      write_reg(CSR_NOISE_SEED, seed);
      write_reg(CSR_BASE_SCALE, scale);
      write_reg(CSR_OCTAVE_COUNT, octaves);
   endtask

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return 12'd0;
         1:       return 12'hFFF;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      logic [31:0] scale;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings
      send_point(12'd0, 12'd0);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'd0, 12'hFFF);
      send_point(12'hFFF, 12'd0);
      send_point(12'd1, 12'd0);
      send_point(12'd0, 12'd1);
      send_point(12'h800, 12'h800);
      send_point(12'hAAA, 12'h555);
      send_point(12'h555, 12'hAAA);

      // all-ones seed and scale, full octave count
      set_noise(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd8);
      send_point(12'd0, 12'd0);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'd1, 12'd1);
      send_point(12'hFFF, 12'd1);
      send_point(12'h7FF, 12'hFFE);

      // zero scale, single octave
      set_noise(32'd0, 32'd0, 32'd1);
      send_point(12'hFFF, 12'h123);
      send_point(12'd0, 12'hFFF);

      // octave count zero behaves as one
      set_noise(32'h1234_5678, 32'd1, 32'd0);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'h3C5, 12'hA5A);

      // octave count above the maximum saturates; spare index is ignored
      set_noise(32'h8000_0001, 32'hFFFF_FFFF, 32'd15);
      write_reg(CSR_SPARE, 32'h0000_0001);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'h001, 12'h800);
      send_point(12'hC00, 12'h003);

      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0:       scale = 32'd0;
            1:       scale = 32'hFFFF;
            default: scale = $urandom();
         endcase
         set_noise($urandom(), scale, $urandom_range(0, 15) | ($urandom() & 32'hFFFF_FFF0));
         if ($urandom_range(0, 2) == 0) write_reg(CSR_SPARE, $urandom());
         steady = (phase == 3);
         repeat (100) send_point(pick_coord(), pick_coord());
      end

      drain();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/fbm_pkg.sv
hw/rtl/fbm_cell.sv
hw/rtl/fbm_norm.sv
hw/rtl/fbm_value_noise.sv
tb/tb.sv
